@@ rtl/u8dec_pkg.sv @@
// shared types and constants for the utf-8 to utf-32/utf-16 decoder
// no dependencies

package u8dec_pkg;

  localparam int CpW = 31;
  localparam int UnitW = 16;

  // config register values
  localparam logic FMT_UTF32 = 1'b0;
  localparam logic FMT_UTF16 = 1'b1;

  localparam logic [CpW-1:0] BMP_MAX = CpW'(32'h0000_FFFF);
  localparam logic [CpW-1:0] SUPP_BASE = CpW'(32'h0001_0000);
  localparam logic [UnitW-1:0] HI_SURR = 16'hD800;
  localparam logic [UnitW-1:0] LO_SURR = 16'hDC00;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       string_start;
  } in_item_t;

  typedef struct packed {
    logic [CpW-1:0] code_unit;
    logic           last_unit;
  } out_item_t;

endpackage

@@ rtl/u8dec_front.sv @@
// front end: takes one byte per transfer, gathers the code point
// and pushes each completed code point to the queue; uses u8dec_pkg

module u8dec_front
  import u8dec_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  in_item_t       in_data,
  input  logic           q_full,
  output logic           q_push,
  output logic [CpW-1:0] q_cp
);

  logic [CpW-1:0] part_r, part_nxt, part_eff;
  logic [2:0]     pend_r, pend_nxt, pend_eff;
  logic           emit;
  logic           accept;
  logic [7:0]     b;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign b        = in_data.data_byte;

  always_comb begin
    // string start drops whatever was pending
    part_eff = in_data.string_start ? '0 : part_r;
    pend_eff = in_data.string_start ? '0 : pend_r;
    part_nxt = part_eff;
    pend_nxt = pend_eff;
    emit     = 1'b0;
    q_cp     = '0;
    if (pend_eff != 3'd0) begin
      // any byte counts as a continuation here
      q_cp     = {part_eff[CpW-7:0], b[5:0]};
      pend_nxt = pend_eff - 3'd1;
      if (pend_nxt == 3'd0) begin
        emit     = 1'b1;
        part_nxt = '0;
      end else begin
        part_nxt = q_cp;
      end
    end else begin
      case (b) inside
        [8'h00:8'h7F]: begin
          emit = 1'b1;
          q_cp = CpW'(b);
        end
        [8'h80:8'hDF]: begin
          part_nxt = CpW'(b[4:0]);
          pend_nxt = 3'd1;
        end
        [8'hE0:8'hEF]: begin
          part_nxt = CpW'(b[3:0]);
          pend_nxt = 3'd2;
        end
        [8'hF0:8'hF7]: begin
          part_nxt = CpW'(b[2:0]);
          pend_nxt = 3'd3;
        end
        [8'hF8:8'hFB]: begin
          part_nxt = CpW'(b[1:0]);
          pend_nxt = 3'd4;
        end
        [8'hFC:8'hFD]: begin
          part_nxt = CpW'(b[0]);
          pend_nxt = 3'd5;
        end
        default: begin
          // 0xfe and 0xff are skipped
          part_nxt = part_eff;
          pend_nxt = pend_eff;
        end
      endcase
    end
  end

  assign q_push = accept && emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      part_r <= '0;
      pend_r <= '0;
    end else if (accept) begin
      part_r <= part_nxt;
      pend_r <= pend_nxt;
    end
  end

  a_pend_range: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= 3'd5)
    else $error("pending count out of range");

endmodule

@@ rtl/u8dec_fifo.sv @@
// short queue of completed code points between front and back end
// uses u8dec_pkg for the code point width

module u8dec_fifo
  import u8dec_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  logic [CpW-1:0] push_cp,
  output logic           full,
  input  logic           pop,
  output logic           not_empty,
  output logic [CpW-1:0] head_cp
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [CpW-1:0] mem_r [DEPTH];
  logic [AW-1:0]  wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;

  assign full      = (cnt_r == CW'(DEPTH));
  assign not_empty = (cnt_r != '0);
  assign head_cp   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cp;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty)
    else $error("pop from empty queue");

endmodule

@@ rtl/u8dec_back.sv @@
// back end: turns queued code points into utf-32 or utf-16 units,
// splitting supplementary points into surrogate pairs; uses u8dec_pkg

module u8dec_back
  import u8dec_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  logic           out_format,
  input  logic           q_not_empty,
  input  logic [CpW-1:0] q_cp,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_ready,
  output out_item_t      out_data
);

  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_data_r, out_data_nxt;
  logic             hold_r, hold_nxt;
  logic [UnitW-1:0] lo_r, lo_nxt;
  logic             load_en;
  logic             split;
  logic [CpW-1:0]   u;
  logic [UnitW-1:0] hi_unit, lo_unit;

  assign load_en = !out_valid_r || out_ready;
  assign split   = (out_format == FMT_UTF16) && (q_cp > BMP_MAX);
  assign u       = q_cp - SUPP_BASE;
  assign hi_unit = u[25:10] + HI_SURR;
  assign lo_unit = LO_SURR | UnitW'(u[9:0]);

  // the low half of a pair goes out before the queue is read again
  assign q_pop = load_en && !hold_r && q_not_empty;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    hold_nxt      = hold_r;
    lo_nxt        = lo_r;
    if (load_en) begin
      if (hold_r) begin
        out_valid_nxt          = 1'b1;
        out_data_nxt.code_unit = CpW'(lo_r);
        out_data_nxt.last_unit = 1'b1;
        hold_nxt               = 1'b0;
      end else if (q_not_empty) begin
        out_valid_nxt = 1'b1;
        if (split) begin
          out_data_nxt.code_unit = CpW'(hi_unit);
          out_data_nxt.last_unit = 1'b0;
          hold_nxt               = 1'b1;
          lo_nxt                 = lo_unit;
        end else begin
          out_data_nxt.code_unit = q_cp;
          out_data_nxt.last_unit = 1'b1;
        end
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      hold_r      <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      hold_r      <= hold_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    lo_r       <= lo_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_hold_high_half: assert property (@(posedge clk) disable iff (!rst_n)
    hold_r |-> (out_valid_r && !out_data_r.last_unit))
    else $error("low surrogate held without high surrogate shown");

  a_not_last_pairs: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data_r.last_unit) |-> hold_r)
    else $error("non-final unit without pending low surrogate");

endmodule

@@ rtl/utf8_to_utf32_utf16_decoder.sv @@
// top level of the utf-8 to utf-32/utf-16 decoder
// instantiates u8dec_front, u8dec_fifo and u8dec_back; uses u8dec_pkg

// Accepts one UTF-8 byte per cycle while the queue is not full (legacy lead
// ranges up to six bytes, no validation, 0xFE/0xFF skipped) and emits code
// points as UTF-32, or as UTF-16 units when cfg_data wrote 1 (reset value). A
// completed code point is written into a QUEUE_DEPTH-entry queue and leaves
// through the output register. The output side sustains one unit per cycle
// while the receiver is ready. A supplementary code point in UTF-16 mode goes
// out as two units (high then low surrogate, last_unit 0 then 1), but
// it needs at least four input bytes, so with the receiver always ready the
// input never stalls; the input only stalls once the queue fills while the
// receiver holds off. Write the format only while idle.

module utf8_to_utf32_utf16_decoder
  import u8dec_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic      cfg_data
);

  logic           fmt_r;
  logic           q_push, q_full, q_pop, q_not_empty;
  logic [CpW-1:0] q_push_cp, q_head_cp;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r <= FMT_UTF16;
    end else if (cfg_valid && cfg_ready) begin
      fmt_r <= cfg_data;
    end
  end

  u8dec_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cp     (q_push_cp)
  );

  u8dec_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_cp   (q_push_cp),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head_cp   (q_head_cp)
  );

  u8dec_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_format  (fmt_r),
    .q_not_empty (q_not_empty),
    .q_cp        (q_head_cp),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

endmodule

@@ bench/tb.sv @@
// self-checking bench for the utf-8 to utf-32/utf-16 decoder: directed and random byte streams
// with a cycle-free decoding predictor; depends on u8dec_pkg and utf8_to_utf32_utf16_decoder

module tb;
  import u8dec_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 8;
  localparam int CHUNK_BYTES = 360;
  localparam int HOLD_CYCLES = 150;
  localparam int HOLD_AFTER = 200;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_data = 1'b0;

  utf8_to_utf32_utf16_decoder dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  in_item_t byte_queue[$];
  out_item_t unit_queue[$];

  // decoder state as the bench sees it
  logic fmt_now = FMT_UTF16;
  logic [CpW-1:0] acc_point = '0;
  logic [2:0] cont_left = '0;

  int send_idle_pct = 13;
  int recv_idle_pct = 58;
  int bytes_taken = 0;
  int errors = 0;
  int quiet_cycles = 0;
  int hold_left = 0;
  logic long_hold_done = 1'b0;

  function automatic void queue_point(input logic [CpW-1:0] cp);
    logic [31:0] off;
    logic [UnitW-1:0] hi16;
    logic [UnitW-1:0] lo16;
    out_item_t u;
    if (fmt_now == FMT_UTF32 || cp <= BMP_MAX) begin
      u.code_unit = cp;
      u.last_unit = 1'b1;
      unit_queue.insert(unit_queue.size(), u);
    end else begin
      off = {1'b0, cp} - {1'b0, SUPP_BASE};
      hi16 = off[25:10] + HI_SURR;
      lo16 = {6'b0, off[9:0]} + LO_SURR;
      u.code_unit = {{(CpW-UnitW){1'b0}}, hi16};
      u.last_unit = 1'b0;
      unit_queue.insert(unit_queue.size(), u);
      u.code_unit = {{(CpW-UnitW){1'b0}}, lo16};
      u.last_unit = 1'b1;
      unit_queue.insert(unit_queue.size(), u);
    end
  endfunction

  function automatic void decode_byte(input in_item_t it);
    logic [CpW-1:0] cp;
    if (it.string_start) begin
      acc_point = '0;
      cont_left = '0;
    end
    if (cont_left != 0) begin
      // any byte counts as a continuation here, only its low six bits matter
      acc_point = {acc_point[CpW-7:0], it.data_byte[5:0]};
      cont_left = cont_left - 3'd1;
      if (cont_left == 0) begin
        cp = acc_point;
        acc_point = '0;
        queue_point(cp);
      end
    end else if (it.data_byte <= 8'h7F) begin
      queue_point({{(CpW-8){1'b0}}, it.data_byte});
    end else if (it.data_byte < 8'hE0) begin
      // stray continuation bytes land here as two-byte leads
      acc_point = {{(CpW-5){1'b0}}, it.data_byte[4:0]};
      cont_left = 3'd1;
    end else if (it.data_byte < 8'hF0) begin
      acc_point = {{(CpW-4){1'b0}}, it.data_byte[3:0]};
      cont_left = 3'd2;
    end else if (it.data_byte < 8'hF8) begin
      acc_point = {{(CpW-3){1'b0}}, it.data_byte[2:0]};
      cont_left = 3'd3;
    end else if (it.data_byte < 8'hFC) begin
      acc_point = {{(CpW-2){1'b0}}, it.data_byte[1:0]};
      cont_left = 3'd4;
    end else if (it.data_byte < 8'hFE) begin
      acc_point = {{(CpW-1){1'b0}}, it.data_byte[0]};
      cont_left = 3'd5;
    end
  endfunction

  // byte driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        decode_byte(in_data);
        bytes_taken++;
      end
      if (!in_valid || in_ready) begin
        if (byte_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data <= byte_queue.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver with one long hold-off once traffic is flowing
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!long_hold_done && bytes_taken >= HOLD_AFTER) begin
      out_ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      long_hold_done <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // result monitor
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (unit_queue.size() == 0) begin
        $error("unexpected unit transfer: code_unit %h last_unit %b",
               out_data.code_unit, out_data.last_unit);
        errors++;
      end else begin
        want = unit_queue.pop_front();
        if (out_data.code_unit !== want.code_unit) begin
          $error("code_unit mismatch: expected %h, actual %h", want.code_unit,
                 out_data.code_unit);
          errors++;
        end
        if (out_data.last_unit !== want.last_unit) begin
          $error("last_unit mismatch: expected %b, actual %b", want.last_unit,
                 out_data.last_unit);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic void push_byte(input logic [7:0] b, input logic s);
    in_item_t it;
    it.data_byte = b;
    it.string_start = s;
    byte_queue.insert(byte_queue.size(), it);
  endfunction

  function automatic logic [7:0] lead_for(input int len);
    case (len)
      1: lead_for = 8'($urandom_range(8'h7F));
      2: lead_for = 8'($urandom_range(8'hDF, 8'h80));
      3: lead_for = 8'($urandom_range(8'hEF, 8'hE0));
      4: lead_for = 8'($urandom_range(8'hF7, 8'hF0));
      5: lead_for = 8'($urandom_range(8'hFB, 8'hF8));
      default: lead_for = 8'($urandom_range(8'hFD, 8'hFC));
    endcase
  endfunction

  function automatic logic [7:0] cont_byte();
    if ($urandom_range(99) < 10)
      cont_byte = 8'($urandom_range(255));
    else
      cont_byte = 8'h80 | 8'($urandom_range(8'h3F));
  endfunction

  function automatic int pick_len();
    int r;
    r = $urandom_range(99);
    if (r < 35) pick_len = 1;
    else if (r < 60) pick_len = 2;
    else if (r < 80) pick_len = 3;
    else if (r < 92) pick_len = 4;
    else if (r < 96) pick_len = 5;
    else pick_len = 6;
  endfunction

  // mostly well-formed sequences, some cut short, some raw noise
  function automatic void queue_random(input int n);
    int count;
    int roll;
    int len;
    int keep;
    logic restart;
    count = 0;
    restart = 1'b1;
    while (count < n) begin
      roll = $urandom_range(99);
      len = pick_len();
      if (roll < 72) begin
        push_byte(lead_for(len), restart || ($urandom_range(99) < 6));
        for (int i = 1; i < len; i++) push_byte(cont_byte(), 1'b0);
        count += len;
        restart = 1'b0;
      end else if (roll < 84) begin
        // truncated: fewer continuations than the lead asks for
        if (len < 2) len = 2;
        keep = $urandom_range(len - 2);
        push_byte(lead_for(len), restart);
        for (int i = 0; i < keep; i++) push_byte(cont_byte(), 1'b0);
        count += keep + 1;
        restart = ($urandom_range(99) < 60);
      end else begin
        push_byte(8'($urandom_range(255)), ($urandom_range(99) < 25));
        count++;
        restart = 1'b0;
      end
    end
  endfunction

  task automatic wait_drained();
    while (byte_queue.size() != 0 || in_valid || unit_queue.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_format(input logic fmt);
    cfg_data <= fmt;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    fmt_now = fmt;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed, under the reset format (utf-16)
    push_byte(8'h00, 1'b1);
    push_byte(8'h7F, 1'b0);
    push_byte(8'h80, 1'b0);  // stray continuation taken as a lead
    push_byte(8'h80, 1'b0);
    push_byte(8'hDF, 1'b0);
    push_byte(8'hBF, 1'b0);
    push_byte(8'hEF, 1'b0);
    push_byte(8'hBF, 1'b0);
    push_byte(8'hBF, 1'b0);
    push_byte(8'hF0, 1'b0);  // first supplementary point, surrogate pair
    push_byte(8'h90, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'hFE, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hFD, 1'b0);  // six-byte lead, continuations of any value
    for (int i = 0; i < 5; i++) push_byte(8'hFF, 1'b0);
    push_byte(8'hE2, 1'b0);  // dropped by the next string start
    push_byte(8'h41, 1'b1);
    push_byte(8'hF8, 1'b0);  // left pending, cut only if the next phase's first byte starts a string
    push_byte(8'h88, 1'b0);
    wait_drained();

    write_format(FMT_UTF32);
    queue_random(CHUNK_BYTES);
    wait_drained();

    send_idle_pct = 58;
    recv_idle_pct = 13;
    write_format(FMT_UTF16);
    queue_random(CHUNK_BYTES);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_format(FMT_UTF32);
    queue_random(CHUNK_BYTES);
    wait_drained();

    write_format(FMT_UTF16);
    queue_random(CHUNK_BYTES);
    wait_drained();

    if (unit_queue.size() != 0) begin
      $error("%0d expected units never arrived", unit_queue.size());
      errors++;
    end
    if (errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

@@ files.f @@
rtl/u8dec_pkg.sv
rtl/u8dec_front.sv
rtl/u8dec_fifo.sv
rtl/u8dec_back.sv
rtl/utf8_to_utf32_utf16_decoder.sv
bench/tb.sv
